/* src/bba_pkg.sv */
package bba_pkg;

    localparam int POOL_ORDER_DEF = 16;
    localparam int MIN_ORDER_DEF  = 4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr;      // write one reset entry of the tree
        logic load;     // take an input item
        logic dn_rd;    // read left child of current node
        logic dn_use;   // pick child, step down
        logic fr_rd;    // read candidate node of the free search
        logic fr_use;   // check candidate, step up one order on a miss
        logic fr_fail;  // free search ran out
        logic mark;     // write the chosen node
        logic up_rd;    // read sibling of current node
        logic up_use;   // write parent, step up
        logic fin;      // load the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        logic err;
        logic is_free;
        logic dn_need;
        logic dn_last;
        logic fr_go;
        logic fr_hit;
        logic at_root;
        logic up_last;
        logic out_free;
    } t_sts;

endpackage

/* src/bba_datapath.sv */
module bba_datapath #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_cmd     i_cmd,
    output bba_pkg::t_sts     o_sts,
    input  logic              i_operation,
    input  logic [16:0]       i_request_size,
    input  logic [15:0]       i_free_offset,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [15:0]       o_block_offset,
    output logic [4:0]        o_granted_order,
    output logic [4:0]        o_largest_free_order
);

    localparam int AW = POOL_ORDER - MIN_ORDER + 1;
    localparam int PW = POOL_ORDER;
    localparam logic [5:0] POOL6 = 6'(POOL_ORDER);
    localparam logic [5:0] MIN6  = 6'(MIN_ORDER);

    logic [4:0]    mem [2**AW];

    logic          r_op;
    logic [1:0]    r_err;
    logic [5:0]    r_ord, n_ord;
    logic [5:0]    r_cur, n_cur;
    logic [AW-1:0] r_h, n_h;
    logic [PW-1:0] r_off, n_off;
    logic [4:0]    r_v, n_v;
    logic [5:0]    r_lvl, n_lvl;
    logic [4:0]    r_root;
    logic [4:0]    r_rdata;
    logic [AW-1:0] r_clr_h;
    logic [4:0]    r_clr_ord;
    logic          r_out_valid;
    logic [1:0]    r_out_st;
    logic [15:0]   r_out_off;
    logic [4:0]    r_out_ord;
    logic [4:0]    r_out_root;

    logic [AW-1:0] rd_addr, wr_addr;
    logic [4:0]    wr_data;
    logic          wr_en;
    logic [31:0]   hf_full;
    logic [AW-1:0] hf;
    logic [16:0]   size_m1;
    logic [5:0]    ord_raw, ord_req;
    logic          oob;
    logic [4:0]    sib, par;

    // round the request up to a power of two
    always_comb begin
        size_m1 = i_request_size - 17'd1;
        ord_raw = '0;
        for (int b = 0; b < 17; b++) begin
            if (size_m1[b]) ord_raw = 6'(b + 1);
        end
        if (i_request_size <= 17'd1) ord_raw = '0;
        ord_req = (ord_raw < MIN6) ? MIN6 : ord_raw;
    end

    assign oob = (32'(i_free_offset) >> POOL_ORDER) != 32'd0;

    assign hf_full = (32'd1 << (POOL6 - r_cur)) | (32'(r_off) >> r_cur);
    assign hf      = hf_full[AW-1:0];

    assign sib = r_rdata;
    always_comb begin
        if (r_v == 5'(r_lvl) && sib == 5'(r_lvl)) par = 5'(r_lvl + 6'd1);
        else if (r_v > sib)                        par = r_v;
        else                                       par = sib;
    end

    always_comb begin
        priority if (i_cmd.dn_rd) rd_addr = {r_h[AW-2:0], 1'b0};
        else if (i_cmd.fr_rd)      rd_addr = hf;
        else if (i_cmd.up_rd)      rd_addr = r_h ^ AW'(1);
        else                       rd_addr = '0;
    end

    always_comb begin
        wr_en   = i_cmd.clr | i_cmd.mark | i_cmd.up_use;
        priority if (i_cmd.clr) begin
            wr_addr = r_clr_h;
            wr_data = r_clr_ord;
        end else if (i_cmd.mark) begin
            wr_addr = r_h;
            wr_data = (r_op == bba_pkg::OP_ALLOC) ? 5'd0 : 5'(r_ord);
        end else begin
            wr_addr = r_h >> 1;
            wr_data = par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        n_ord = r_ord;
        n_cur = r_cur;
        n_h   = r_h;
        n_off = r_off;
        n_v   = r_v;
        n_lvl = r_lvl;
        if (i_cmd.load) begin
            n_ord = (i_operation == bba_pkg::OP_FREE) ? MIN6 : ord_req;
            n_cur = (i_operation == bba_pkg::OP_FREE) ? MIN6 : POOL6;
            n_h   = AW'(1);
            n_off = (i_operation == bba_pkg::OP_FREE) ? PW'(i_free_offset) : '0;
        end
        if (i_cmd.dn_use) begin
            n_cur = r_cur - 6'd1;
            if (r_rdata >= 5'(r_ord)) begin
                n_h = {r_h[AW-2:0], 1'b0};
            end else begin
                n_h   = {r_h[AW-2:0], 1'b1};
                n_off = r_off | (PW'(1) << (r_cur - 6'd1));
            end
        end
        if (i_cmd.fr_rd) n_h = hf;
        if (i_cmd.fr_use) begin
            if (r_rdata == 5'd0) n_ord = r_cur;
            else                 n_cur = r_cur + 6'd1;
        end
        if (i_cmd.mark) begin
            n_v   = wr_data;
            n_lvl = r_ord;
        end
        if (i_cmd.up_use) begin
            n_v   = par;
            n_lvl = r_lvl + 6'd1;
            n_h   = r_h >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord <= n_ord;
        r_cur <= n_cur;
        r_h   <= n_h;
        r_off <= n_off;
        r_v   <= n_v;
        r_lvl <= n_lvl;
        if (i_cmd.load) r_op <= i_operation;
        if (i_cmd.fin) begin
            r_out_st   <= r_err;
            r_out_off  <= (r_err == bba_pkg::ST_OK) ? 16'(r_off) : 16'd0;
            r_out_ord  <= (r_err == bba_pkg::ST_OK) ? 5'(r_ord) : 5'd0;
            r_out_root <= r_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= bba_pkg::ST_OK;
            r_root      <= 5'(POOL_ORDER);
            r_clr_h     <= AW'(1);
            r_clr_ord   <= 5'(POOL_ORDER);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_operation == bba_pkg::OP_FREE)
                    r_err <= oob ? bba_pkg::ST_NOT_ALLOC : bba_pkg::ST_OK;
                else if (i_request_size == 17'd0)
                    r_err <= bba_pkg::ST_ZERO_SIZE;
                else if (ord_req > 6'(r_root))
                    r_err <= bba_pkg::ST_NO_SPACE;
                else
                    r_err <= bba_pkg::ST_OK;
            end
            if (i_cmd.fr_fail) r_err <= bba_pkg::ST_NOT_ALLOC;
            if (wr_en && wr_addr == AW'(1)) r_root <= wr_data;
            if (i_cmd.clr) begin
                r_clr_h <= r_clr_h + AW'(1);
                if (((r_clr_h + AW'(1)) & r_clr_h) == '0) r_clr_ord <= r_clr_ord - 5'd1;
            end
            if (i_cmd.fin)        r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clr_done = &r_clr_h;
        o_sts.err      = r_err != bba_pkg::ST_OK;
        o_sts.is_free  = r_op == bba_pkg::OP_FREE;
        o_sts.dn_need  = r_cur > r_ord;
        o_sts.dn_last  = (r_cur - 6'd1) == r_ord;
        o_sts.fr_go    = (r_cur <= POOL6)
                         && ((32'(r_off) & ((32'd1 << r_cur) - 32'd1)) == 32'd0);
        o_sts.fr_hit   = r_rdata == 5'd0;
        o_sts.at_root  = r_h == AW'(1);
        o_sts.up_last  = (r_h >> 1) == AW'(1);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_st;
    assign o_block_offset       = r_out_off;
    assign o_granted_order      = r_out_ord;
    assign o_largest_free_order = r_out_root;

endmodule

/* src/bba_ctrl.sv */
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISPATCH = 11'b000_0000_0100,
        S_DN_RD    = 11'b000_0000_1000,
        S_DN_USE   = 11'b000_0001_0000,
        S_FR_RD    = 11'b000_0010_0000,
        S_FR_USE   = 11'b000_0100_0000,
        S_MARK     = 11'b000_1000_0000,
        S_UP_RD    = 11'b001_0000_0000,
        S_UP_USE   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.err)  n_state = S_DONE;
                else if (i_sts.is_free)  n_state = S_FR_RD;
                else if (i_sts.dn_need)  n_state = S_DN_RD;
                else                     n_state = S_MARK;
            end
            S_DN_RD: begin
                o_cmd.dn_rd = 1'b1;
                n_state     = S_DN_USE;
            end
            S_DN_USE: begin
                o_cmd.dn_use = 1'b1;
                n_state      = i_sts.dn_last ? S_MARK : S_DN_RD;
            end
            S_FR_RD: begin
                if (i_sts.fr_go) begin
                    o_cmd.fr_rd = 1'b1;
                    n_state     = S_FR_USE;
                end else begin
                    o_cmd.fr_fail = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_FR_USE: begin
                o_cmd.fr_use = 1'b1;
                n_state      = i_sts.fr_hit ? S_MARK : S_FR_RD;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = i_sts.at_root ? S_DONE : S_UP_RD;
            end
            S_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state     = S_UP_USE;
            end
            S_UP_USE: begin
                o_cmd.up_use = 1'b1;
                n_state      = i_sts.up_last ? S_DONE : S_UP_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_ready = r_state == S_IDLE;

endmodule

/* src/buddy_block_allocator_top.sv */
// Channel | Handshake          | Fields
// in      | i_valid / o_ready  | i_operation, i_request_size, i_free_offset
// out     | o_valid / i_ready  | o_status, o_block_offset, o_granted_order,
//         |                    | o_largest_free_order
//
// One item at a time; the tree sits in one memory with a registered read port, so a
// tree level takes a read state and a use state. Allocate descends from the root to
// the granted order, marks the node and climbs back to the root; free searches up from
// MIN_ORDER for an allocated node; zero size and no space go straight to the result.
// After reset a clearing pass writes 2^(POOL_ORDER-MIN_ORDER+1)-1 entries, one a cycle
// (8191 at default), with o_ready low. A new item is taken while the last result
// waits; a finished item holds in its final state until the result register is free.
module buddy_block_allocator_top #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_free_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_block_offset,
    output logic [4:0]  o_granted_order,
    output logic [4:0]  o_largest_free_order
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    // sequence the walk: clear, descend or search, mark, climb, report
    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold the tree memory, walk registers and the result register
    bba_datapath #(
        .POOL_ORDER (POOL_ORDER),
        .MIN_ORDER  (MIN_ORDER)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_operation          (i_operation),
        .i_request_size       (i_request_size),
        .i_free_offset        (i_free_offset),
        .i_out_ready          (i_ready),
        .o_out_valid          (o_valid),
        .o_status             (o_status),
        .o_block_offset       (o_block_offset),
        .o_granted_order      (o_granted_order),
        .o_largest_free_order (o_largest_free_order)
    );

endmodule

/* src/bba_checker.sv */
module bba_checker #(
    parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_block_offset,
    input logic [4:0]  o_granted_order,
    input logic [4:0]  o_largest_free_order
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
                                && $stable(o_block_offset) && $stable(o_granted_order))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bba_pkg::ST_OK |-> o_block_offset == 16'd0
                                                  && o_granted_order == 5'd0)
        else $error("error result carries a block");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bba_pkg::ST_OK |-> o_granted_order >= 5'(MIN_ORDER)
                                                  && o_granted_order <= 5'(POOL_ORDER))
        else $error("granted order out of range");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_largest_free_order <= 5'(POOL_ORDER))
        else $error("largest free order out of range");

endmodule

bind buddy_block_allocator_top bba_checker #(
    .POOL_ORDER (POOL_ORDER),
    .MIN_ORDER  (MIN_ORDER)
) u_bba_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_ready              (i_ready),
    .o_status             (o_status),
    .o_block_offset       (o_block_offset),
    .o_granted_order      (o_granted_order),
    .o_largest_free_order (o_largest_free_order)
);
